>>> hdl/fdfc_pkg.sv
// Shared constants and types for the fractional delay feedback comb.
`timescale 1ns / 1ps

package fdfc_pkg;

    localparam int SAMPLE_W  = 16;
    localparam int DEPTH     = 1024;
    localparam int ADDR_W    = $clog2(DEPTH);
    localparam int FRAC_BITS = 8;
    localparam int DELAY_W   = 18;
    localparam int GAIN_W    = 16;
    localparam int PADDR_W   = 3;
    localparam int PDATA_W   = 32;

    // Largest usable delay: one LSB below DEPTH-1 whole samples.
    localparam longint unsigned DELAY_MAX =
        (longint'(DEPTH - 1) * (longint'(1) << FRAC_BITS)) - 1;
    localparam int GAIN_LIMIT = 32735;

    // Register index, taken from paddr[2].
    localparam logic REG_DELAY = 1'b0;
    localparam logic REG_GAIN  = 1'b1;

    typedef struct packed {
        logic                rd_en;
        logic [ADDR_W-1:0]   dint;
        logic                wr_en;
        logic [SAMPLE_W-1:0] wdata;
    } store_req_t;

endpackage

>>> hdl/fdfc_delay_store.sv
// Circular delay store with write pointer, fill tracking and two registered taps.
`timescale 1ns / 1ps

module fdfc_delay_store
(
    input  logic                              clk,
    input  logic                              rst_n,
    input  fdfc_pkg::store_req_t              req,
    output logic signed [fdfc_pkg::SAMPLE_W-1:0] tap_a,
    output logic signed [fdfc_pkg::SAMPLE_W-1:0] tap_b
);

    logic [fdfc_pkg::SAMPLE_W-1:0] mem [fdfc_pkg::DEPTH];

    logic [fdfc_pkg::ADDR_W-1:0] wp_reg, wp_next;
    logic                        full_reg, full_next;
    logic [fdfc_pkg::SAMPLE_W-1:0] qa_reg, qb_reg;
    logic                        va_reg, vb_reg;

    logic [fdfc_pkg::ADDR_W:0]   sum_a;
    logic [fdfc_pkg::ADDR_W-1:0] ia, ib;
    logic                        va, vb;

    // Tap A sits dint entries behind the write pointer, tap B one further.
    always_comb
    begin
        sum_a = {1'b0, wp_reg} + (fdfc_pkg::ADDR_W+1)'(fdfc_pkg::DEPTH) - {1'b0, req.dint};
        if (sum_a >= (fdfc_pkg::ADDR_W+1)'(fdfc_pkg::DEPTH))
        begin
            sum_a = sum_a - (fdfc_pkg::ADDR_W+1)'(fdfc_pkg::DEPTH);
        end
        ia = sum_a[fdfc_pkg::ADDR_W-1:0];
        if (ia == '0)
        begin
            ib = fdfc_pkg::ADDR_W'(fdfc_pkg::DEPTH - 1);
        end
        else
        begin
            ib = ia - 1'b1;
        end
        // Entries are filled in order from zero, so an entry holds data once the
        // pointer has passed it or the store has wrapped.
        va = full_reg || (ia < wp_reg);
        vb = full_reg || (ib < wp_reg);
    end

    always_comb
    begin
        wp_next   = wp_reg;
        full_next = full_reg;
        if (req.wr_en)
        begin
            if (wp_reg == fdfc_pkg::ADDR_W'(fdfc_pkg::DEPTH - 1))
            begin
                wp_next   = '0;
                full_next = 1'b1;
            end
            else
            begin
                wp_next = wp_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg   <= '0;
            full_reg <= 1'b0;
        end
        else
        begin
            wp_reg   <= wp_next;
            full_reg <= full_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.wr_en)
        begin
            mem[wp_reg] <= req.wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.rd_en)
        begin
            qa_reg <= mem[ia];
            qb_reg <= mem[ib];
            va_reg <= va;
            vb_reg <= vb;
        end
    end

    assign tap_a = va_reg ? $signed(qa_reg) : '0;
    assign tap_b = vb_reg ? $signed(qb_reg) : '0;

endmodule

>>> hdl/fractional_delay_feedback_comb_unit.sv
// Top level of the fractional delay feedback comb: handshakes, registers, arithmetic.
`timescale 1ns / 1ps

// Feedback comb filter with a linearly interpolated fractional delay. Each Q1.15
// sample accepted on the slave stream gives one Q1.15 sample on the master stream,
// the interpolation of two taps read from a 1024-entry delay store at the integer
// delay behind the write pointer and one entry further. Input plus gain times that
// output, rounded and saturated, is written back at the write pointer. One sample
// passes through four states: accept, store read, interpolation multiply, and feedback
// multiply with write-back; the feedback step holds while a previous result has not
// been taken. The store reads as zero after reset without a clearing pass, since a
// fill mark tracks which entries have been written. Delay (register 0, address 0)
// is unsigned with 8 fractional bits and is clamped to one LSB below 1023 samples;
// feedback gain (register 1, address 4) is Q1.15 and is clamped to plus or minus
// 0.999. Write the registers only while no sample is in flight.

module fractional_delay_feedback_comb_unit
(
    input  logic                            clk,
    input  logic                            rst_n,

    // Slave stream: tdata[15:0] = sample_in
    input  logic                            s_axis_tvalid,
    output logic                            s_axis_tready,
    input  logic [15:0]                     s_axis_tdata,

    // Master stream: tdata[15:0] = sample_out
    output logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    output logic [15:0]                     m_axis_tdata,

    // APB configuration port
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [fdfc_pkg::PADDR_W-1:0]    paddr,
    input  logic [fdfc_pkg::PDATA_W-1:0]    pwdata,
    output logic [fdfc_pkg::PDATA_W-1:0]    prdata,
    output logic                            pready
);

    typedef enum logic [3:0] {
        ST_IDLE     = 4'b0001,
        ST_READ     = 4'b0010,
        ST_INTERP   = 4'b0100,
        ST_FEEDBACK = 4'b1000
    } state_t;

    localparam int DIFF_W = fdfc_pkg::SAMPLE_W + 1;
    localparam int ACC_W  = DIFF_W + fdfc_pkg::FRAC_BITS + 2;
    localparam int V_W    = 2 * fdfc_pkg::SAMPLE_W + 1;

    state_t state_reg, state_next;

    logic [fdfc_pkg::DELAY_W-1:0] delay_reg, delay_next;
    logic [fdfc_pkg::GAIN_W-1:0]  gain_reg, gain_next;

    logic signed [fdfc_pkg::SAMPLE_W-1:0] x_reg, x_next;
    logic signed [fdfc_pkg::GAIN_W-1:0]   g_reg, g_next;
    logic [fdfc_pkg::FRAC_BITS-1:0]       f_reg, f_next;
    logic [fdfc_pkg::ADDR_W-1:0]          dint_reg, dint_next;
    logic signed [fdfc_pkg::SAMPLE_W-1:0] y_reg, y_next;

    logic                          out_valid_reg, out_valid_next;
    logic [fdfc_pkg::SAMPLE_W-1:0] out_data_reg, out_data_next;

    logic                          cfg_wr;
    logic                          in_fire;
    logic                          fb_go;
    logic [fdfc_pkg::DELAY_W-1:0]  d_clamped;
    logic signed [fdfc_pkg::GAIN_W-1:0] g_raw, g_clamped;

    logic signed [fdfc_pkg::SAMPLE_W-1:0] tap_a, tap_b;
    logic signed [DIFF_W-1:0]             diff;
    logic signed [ACC_W-1:0]              acc;

    logic signed [V_W-1:0]                v;
    logic signed [V_W-fdfc_pkg::SAMPLE_W:0] w_wide;
    logic signed [fdfc_pkg::SAMPLE_W-1:0] w_sat;

    fdfc_pkg::store_req_t store_req;

    // APB: zero-wait, writes land on the access phase.
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_comb
    begin
        unique case (paddr[2])
            fdfc_pkg::REG_DELAY: prdata = fdfc_pkg::PDATA_W'(delay_reg);
            fdfc_pkg::REG_GAIN:  prdata = fdfc_pkg::PDATA_W'(gain_reg);
            default:             prdata = '0;
        endcase
    end

    always_comb
    begin
        delay_next = delay_reg;
        gain_next  = gain_reg;
        if (cfg_wr)
        begin
            unique case (paddr[2])
                fdfc_pkg::REG_DELAY: delay_next = pwdata[fdfc_pkg::DELAY_W-1:0];
                fdfc_pkg::REG_GAIN:  gain_next  = pwdata[fdfc_pkg::GAIN_W-1:0];
                default:             ;
            endcase
        end
    end

    // Clamp the registers once per transaction, at acceptance.
    always_comb
    begin
        if (64'(delay_reg) > fdfc_pkg::DELAY_MAX)
        begin
            d_clamped = fdfc_pkg::DELAY_W'(fdfc_pkg::DELAY_MAX);
        end
        else
        begin
            d_clamped = delay_reg;
        end

        g_raw = $signed(gain_reg);
        if (g_raw > fdfc_pkg::GAIN_W'(fdfc_pkg::GAIN_LIMIT))
        begin
            g_clamped = fdfc_pkg::GAIN_W'(fdfc_pkg::GAIN_LIMIT);
        end
        else if (g_raw < -fdfc_pkg::GAIN_W'(fdfc_pkg::GAIN_LIMIT))
        begin
            g_clamped = -fdfc_pkg::GAIN_W'(fdfc_pkg::GAIN_LIMIT);
        end
        else
        begin
            g_clamped = g_raw;
        end
    end

    assign s_axis_tready = (state_reg == ST_IDLE);
    assign in_fire       = s_axis_tvalid && s_axis_tready;

    // Feedback step may proceed only when the output register is free or emptying.
    assign fb_go = !out_valid_reg || m_axis_tready;

    // Interpolate as a + (b - a) * f with round half up; one multiplier.
    always_comb
    begin
        diff = DIFF_W'(tap_b) - DIFF_W'(tap_a);
        acc  = (ACC_W'(tap_a) <<< fdfc_pkg::FRAC_BITS)
             + ACC_W'(diff * $signed({1'b0, f_reg}))
             + ACC_W'(1 << (fdfc_pkg::FRAC_BITS - 1));
    end

    // Feedback: x * 2^15 + g * y in Q3.30, round half up, saturate to Q1.15.
    always_comb
    begin
        v = (V_W'(x_reg) <<< (fdfc_pkg::SAMPLE_W - 1))
          + V_W'(g_reg * y_reg)
          + V_W'(1 << (fdfc_pkg::SAMPLE_W - 2));
        w_wide = $signed(v[V_W-1:fdfc_pkg::SAMPLE_W-1]);
        if (w_wide > (V_W-fdfc_pkg::SAMPLE_W+1)'(32767))
        begin
            w_sat = 16'sh7FFF;
        end
        else if (w_wide < -(V_W-fdfc_pkg::SAMPLE_W+1)'(32768))
        begin
            w_sat = 16'sh8000;
        end
        else
        begin
            w_sat = w_wide[fdfc_pkg::SAMPLE_W-1:0];
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        x_next         = x_reg;
        g_next         = g_reg;
        f_next         = f_reg;
        dint_next      = dint_reg;
        y_next         = y_reg;
        out_valid_next = out_valid_reg;
        out_data_next  = out_data_reg;

        store_req.rd_en = 1'b0;
        store_req.dint  = dint_reg;
        store_req.wr_en = 1'b0;
        store_req.wdata = w_sat;

        // Drop the result once the sink has taken it.
        if (out_valid_reg && m_axis_tready)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_fire)
                begin
                    x_next     = $signed(s_axis_tdata);
                    g_next     = g_clamped;
                    f_next     = d_clamped[fdfc_pkg::FRAC_BITS-1:0];
                    dint_next  = fdfc_pkg::ADDR_W'(d_clamped >> fdfc_pkg::FRAC_BITS);
                    state_next = ST_READ;
                end
            end
            ST_READ:
            begin
                store_req.rd_en = 1'b1;
                state_next      = ST_INTERP;
            end
            ST_INTERP:
            begin
                y_next     = acc[fdfc_pkg::FRAC_BITS +: fdfc_pkg::SAMPLE_W];
                state_next = ST_FEEDBACK;
            end
            ST_FEEDBACK:
            begin
                // Hold until the output register can take the result.
                if (fb_go)
                begin
                    store_req.wr_en = 1'b1;
                    out_valid_next  = 1'b1;
                    out_data_next   = y_reg;
                    state_next      = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            delay_reg     <= '0;
            gain_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            delay_reg     <= delay_next;
            gain_reg      <= gain_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        x_reg        <= x_next;
        g_reg        <= g_next;
        f_reg        <= f_next;
        dint_reg     <= dint_next;
        y_reg        <= y_next;
        out_data_reg <= out_data_next;
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;

    fdfc_delay_store u_store
    (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (store_req),
        .tap_a (tap_a),
        .tap_b (tap_b)
    );

endmodule
